@@ design/sri_pkg.sv @@
// Shared constants and types for the Sellmeier refractive index pipeline.
// No dependencies; imported by every module of the block.
package sri_pkg;

  localparam int WAVE_W  = 16;  // wavelength, Q10.6 nm
  localparam int COEF_W  = 32;  // B and C coefficients, Q8.24
  localparam int SQ_W    = 32;  // w*w
  localparam int QA_W    = 19;  // floor(w*w / 15625)
  localparam int YR_W    = 20;  // 64*remainder + rounding offset
  localparam int LSQ_W   = 25;  // squared wavelength, Q1.24 um^2
  localparam int KDIV_W  = 14;  // width of the nm->um scale divisor
  localparam int DIFF_W  = 34;  // signed l2 - c
  localparam int NUM_W   = 61;  // b*l2*16
  localparam int N2_W    = 64;  // signed n2, Q.28
  localparam int RAD_W   = 64;  // sqrt radicand
  localparam int ROOT_W  = 32;  // sqrt root, Q4.28
  localparam int SREM_W  = 34;  // sqrt partial remainder
  localparam int NTERMS  = 3;

  // Reciprocals of 15625: exact for w*w below 2^32 and for 64*r+7812 below 2^20.
  localparam int RECIP_A_SH = 45;
  localparam int RECIP_B_W  = 18;
  localparam int RECIP_B_SH = 31;

  localparam logic [KDIV_W-1:0]    SCALE_DIV   = KDIV_W'(15625);
  localparam logic [SQ_W-1:0]      RECIP_A     = SQ_W'(32'd2251799814);
  localparam logic [RECIP_B_W-1:0] RECIP_B     = RECIP_B_W'(18'd137439);
  localparam logic [YR_W-1:0]      ROUND_ADD   = YR_W'(7812);
  localparam logic [N2_W-1:0]      ONE_Q28     = N2_W'(64'h1000_0000);
  localparam logic [N2_W-1:0]      N2_LIMIT    = N2_W'(64'h10_0000_0000);
  localparam logic [ROOT_W-1:0]    INDEX_SAT   = '1;
  localparam logic [ROOT_W-1:0]    INDEX_ONE   = ROOT_W'(32'h1000_0000);

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_B1 = 3'd0;
  localparam cfg_idx_t CFG_B2 = 3'd1;
  localparam cfg_idx_t CFG_B3 = 3'd2;
  localparam cfg_idx_t CFG_C1 = 3'd3;
  localparam cfg_idx_t CFG_C2 = 3'd4;
  localparam cfg_idx_t CFG_C3 = 3'd5;

  // Flags carried alongside the square root cells.
  typedef struct packed {
    logic sat;
    logic clamped;
    logic pole;
  } sri_flags_t;

endpackage

@@ design/sri_div_cell.sv @@
// One restoring long-division step: one quotient bit per cell.
// Depends on sri_pkg for default widths.
module sri_div_cell #(
  parameter int NW = sri_pkg::NUM_W,
  parameter int DW = sri_pkg::COEF_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [NW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] div_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  import sri_pkg::*;

  logic          vld_r;
  logic [NW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt, div_r;
  logic [SW-1:0] side_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial   = {rem_i, num_i[NW-1]};
    diff    = trial - {1'b0, div_i};
    ge      = (trial >= {1'b0, div_i});
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_nxt = {quo_i[NW-2:0], ge};
    num_nxt = {num_i[NW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      div_r  <= div_i;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign num_o  = num_r;
  assign rem_o  = rem_r;
  assign div_o  = div_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;
endmodule

@@ design/sri_sqrt_cell.sv @@
// One digit-by-digit square root step: one root bit per cell.
// Depends on sri_pkg for widths and the flag struct.
module sri_sqrt_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [sri_pkg::RAD_W-1:0]  rad_i,
  input  logic [sri_pkg::SREM_W-1:0] rem_i,
  input  logic [sri_pkg::ROOT_W-1:0] root_i,
  input  sri_pkg::sri_flags_t        flg_i,
  output logic                       vld_o,
  output logic [sri_pkg::RAD_W-1:0]  rad_o,
  output logic [sri_pkg::SREM_W-1:0] rem_o,
  output logic [sri_pkg::ROOT_W-1:0] root_o,
  output sri_pkg::sri_flags_t        flg_o
);
  import sri_pkg::*;

  logic              vld_r;
  logic [RAD_W-1:0]  rad_r;
  logic [SREM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  sri_flags_t        flg_r;
  logic [SREM_W+1:0] cur, trial, diff;
  logic              ge;

  always_comb begin
    cur      = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    diff     = cur - trial;
    ge       = (cur >= trial);
    rem_nxt  = ge ? diff[SREM_W-1:0] : cur[SREM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      flg_r  <= flg_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign flg_o  = flg_r;
endmodule

@@ design/sellmeier_refractive_index.sv @@
// Top level of the three-term Sellmeier refractive index pipeline.
// Depends on sri_pkg, sri_div_cell and sri_sqrt_cell.
//
// Usage:
//   in_*  : one word per wavelength, in_tdata[15:0] = wavelength (Q10.6 nm).
//   out_* : one word per input, out_tdata = index_value (Q4.28),
//           out_tuser[0] = pole_hit, out_tuser[1] = floor_clamped.
//   cfg_* : coefficient writes, index 0..2 = B1..B3, 3..5 = C1..C3 (Q8.24);
//           other indexes are dropped. cfg_ready is always high. Write only
//           while no word is in flight.
// Throughput: one word per cycle while the chain is not held. A word passes
// through the chain: three parallel lanes of 61 division cells form the terms
// and 32 square root cells produce the index, plus eight registered arithmetic
// stages (input, square, two reciprocal scaling steps, l2, term setup, sum, clamp)
// and the output register.
// Reset clears all valid bits, the output and skid valid flags and the
// coefficients (all zero: B=0 gives index one, and a wavelength whose square
// rounds to zero hits a pole until C is written).
// Stall: the output register is backed by a one-word skid register. When the
// receiver stalls, the chain keeps moving until a word lands in the skid;
// then in_tready drops and the whole chain holds until the skid drains.
module sellmeier_refractive_index (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,   // [15:0] wavelength
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [31:0] index_value
  output logic [1:0]                 out_tuser,  // [0] pole_hit, [1] floor_clamped
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  sri_pkg::cfg_idx_t          cfg_index,
  input  logic [sri_pkg::COEF_W-1:0] cfg_data
);
  import sri_pkg::*;

  localparam int ND = NUM_W;   // cells per term divider
  localparam int NS = ROOT_W;  // square root cells

  logic en;

  // ---------------- coefficient registers ----------------
  logic [COEF_W-1:0] coef_b_r [NTERMS];
  logic [COEF_W-1:0] coef_c_r [NTERMS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NTERMS; k++) begin
        coef_b_r[k] <= '0;
        coef_c_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_B1:  coef_b_r[0] <= cfg_data;
        CFG_B2:  coef_b_r[1] <= cfg_data;
        CFG_B3:  coef_b_r[2] <= cfg_data;
        CFG_C1:  coef_c_r[0] <= cfg_data;
        CFG_C2:  coef_c_r[1] <= cfg_data;
        CFG_C3:  coef_c_r[2] <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------- input, square and scaling to um^2 ----------------
  // L = round(w*w*64 / 15625). Split w*w = 15625*qa + r, then
  // L = 64*qa + floor((64*r + 7812) / 15625); both quotients come from
  // reciprocal multiplies that are exact over their operand range.
  logic                                  v0_r, v1_r, vq_r, vy_r, vl_r;
  logic [WAVE_W-1:0]                     w0_r;
  logic [SQ_W-1:0]                       sq_r, sq2_r;
  logic [QA_W-1:0]                       qa_r, qa2_r;
  logic [YR_W-1:0]                       yr_r;
  logic [LSQ_W-1:0]                      lsq_r;
  logic [2*SQ_W-1:0]                     qa_prod;
  logic [QA_W+KDIV_W-1:0]                qa_back;
  logic [SQ_W-1:0]                       rem_full;
  logic [YR_W+RECIP_B_W-1:0]             qb_prod;
  logic [YR_W+RECIP_B_W-RECIP_B_SH-1:0]  qb;

  assign in_tready = en;
  assign qa_prod   = sq_r * RECIP_A;
  assign qa_back   = qa_r * SCALE_DIV;
  assign rem_full  = sq2_r - qa_back[SQ_W-1:0];
  assign qb_prod   = yr_r * RECIP_B;
  assign qb        = qb_prod[YR_W+RECIP_B_W-1:RECIP_B_SH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vq_r <= 1'b0;
      vy_r <= 1'b0;
      vl_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      vq_r <= v1_r;
      vy_r <= vq_r;
      vl_r <= vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r  <= in_tdata;
      sq_r  <= w0_r * w0_r;
      qa_r  <= qa_prod[2*SQ_W-1:RECIP_A_SH];
      sq2_r <= sq_r;
      // 64*r plus half the divisor, for round to nearest
      yr_r  <= {rem_full[KDIV_W-1:0], 6'b0} + ROUND_ADD;
      qa2_r <= qa_r;
      lsq_r <= {qa2_r, 6'b0} + LSQ_W'(qb);
    end
  end

  // ---------------- term setup: difference and numerator ----------------
  logic               v2_r;
  logic [NUM_W-1:0]   tnum_r [NTERMS];
  logic [COEF_W-1:0]  tmag_r [NTERMS];
  logic [1:0]         tsd_r  [NTERMS];  // {zero, negative}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= vl_r;
    end
  end

  for (genvar k = 0; k < NTERMS; k++) begin : g_setup
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        dneg;
    logic [COEF_W+LSQ_W-1:0]  prod;

    assign d    = $signed({{(DIFF_W-LSQ_W){1'b0}}, lsq_r})
                - $signed({{(DIFF_W-COEF_W){1'b0}}, coef_c_r[k]});
    assign dneg = -d;
    assign prod = coef_b_r[k] * lsq_r;

    always_ff @(posedge clk) begin
      if (en) begin
        tnum_r[k] <= {prod, 4'b0};
        tmag_r[k] <= d[DIFF_W-1] ? dneg[COEF_W-1:0] : d[COEF_W-1:0];
        tsd_r[k]  <= {(d == '0), d[DIFF_W-1]};
      end
    end
  end

  // ---------------- term dividers, three lanes ----------------
  logic              dv   [NTERMS][ND+1];
  logic [NUM_W-1:0]  dnum [NTERMS][ND+1];
  logic [COEF_W-1:0] drem [NTERMS][ND+1];
  logic [COEF_W-1:0] ddiv [NTERMS][ND+1];
  logic [NUM_W-1:0]  dquo [NTERMS][ND+1];
  logic [1:0]        dsd  [NTERMS][ND+1];

  for (genvar k = 0; k < NTERMS; k++) begin : g_lane
    assign dv[k][0]   = v2_r;
    assign dnum[k][0] = tnum_r[k];
    assign drem[k][0] = '0;
    assign ddiv[k][0] = tmag_r[k];
    assign dquo[k][0] = '0;
    assign dsd[k][0]  = tsd_r[k];

    for (genvar i = 0; i < ND; i++) begin : g_dcell
      sri_div_cell #(.NW(NUM_W), .DW(COEF_W), .SW(2)) u_cell (
        .clk, .rst_n, .en,
        .vld_i(dv[k][i]), .num_i(dnum[k][i]), .rem_i(drem[k][i]),
        .div_i(ddiv[k][i]), .quo_i(dquo[k][i]), .side_i(dsd[k][i]),
        .vld_o(dv[k][i+1]), .num_o(dnum[k][i+1]), .rem_o(drem[k][i+1]),
        .div_o(ddiv[k][i+1]), .quo_o(dquo[k][i+1]), .side_o(dsd[k][i+1])
      );
    end
  end

  // ---------------- sum of terms ----------------
  logic                   v3_r, pole3_r;
  logic signed [N2_W-1:0] n2_r, n2_nxt;
  logic signed [N2_W-1:0] term [NTERMS];
  logic                   pole_any;

  always_comb begin
    pole_any = 1'b0;
    for (int k = 0; k < NTERMS; k++) begin
      term[k] = $signed({{(N2_W-NUM_W){1'b0}}, dquo[k][ND]});
      if (dsd[k][ND][1]) begin
        term[k]  = '0;  // pole lane contributes nothing
        pole_any = 1'b1;
      end else if (dsd[k][ND][0]) begin
        term[k] = -term[k];
      end
    end
    n2_nxt = $signed(ONE_Q28) + term[0] + term[1] + term[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= dv[0][ND] & dv[1][ND] & dv[2][ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r    <= n2_nxt;
      pole3_r <= pole_any;
    end
  end

  // ---------------- clamp and range check ----------------
  logic             v4_r;
  logic [RAD_W-1:0] rad_r;
  sri_flags_t       flg4_r, flg4_nxt;
  logic [N2_W-1:0]  n2c;

  always_comb begin
    flg4_nxt.pole    = pole3_r;
    flg4_nxt.clamped = ~pole3_r & (n2_r < $signed(ONE_Q28));
    n2c              = flg4_nxt.clamped ? ONE_Q28 : n2_r;
    flg4_nxt.sat     = pole3_r | (n2c >= N2_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {n2c[35:0], 28'b0};
      flg4_r <= flg4_nxt;
    end
  end

  // ---------------- square root cells ----------------
  logic              sv   [NS+1];
  logic [RAD_W-1:0]  srad [NS+1];
  logic [SREM_W-1:0] srem [NS+1];
  logic [ROOT_W-1:0] sroot[NS+1];
  sri_flags_t        sflg [NS+1];

  assign sv[0]    = v4_r;
  assign srad[0]  = rad_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sflg[0]  = flg4_r;

  for (genvar i = 0; i < NS; i++) begin : g_scell
    sri_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .vld_i(sv[i]), .rad_i(srad[i]), .rem_i(srem[i]), .root_i(sroot[i]),
      .flg_i(sflg[i]),
      .vld_o(sv[i+1]), .rad_o(srad[i+1]), .rem_o(srem[i+1]),
      .root_o(sroot[i+1]), .flg_o(sflg[i+1])
    );
  end

  logic              tail_v;
  logic [ROOT_W+1:0] tail_d;  // {clamped, pole, index}
  assign tail_v = sv[NS];
  assign tail_d = {sflg[NS].clamped, sflg[NS].pole,
                   sflg[NS].sat ? INDEX_SAT : sroot[NS]};

  // ---------------- output register and skid ----------------
  logic              out_vld_r, sk_vld_r;
  logic [ROOT_W+1:0] out_dat_r, sk_dat_r;
  logic              out_free;

  assign en       = ~sk_vld_r;
  assign out_free = ~out_vld_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (sk_vld_r) begin
      // chain holds; drain the skid once the receiver takes the word
      if (out_tready) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end
    end else if (out_free) begin
      out_vld_r <= tail_v;
    end else if (tail_v) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_vld_r) begin
      if (out_tready) begin
        out_dat_r <= sk_dat_r;
      end
    end else if (out_free) begin
      out_dat_r <= tail_d;
    end else begin
      sk_dat_r <= tail_d;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r[ROOT_W-1:0];
  assign out_tuser  = out_dat_r[ROOT_W+1:ROOT_W];

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_vld_r |-> out_vld_r)
    else $error("skid holds a word while output register is empty");

  a_pole_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_dat_r[ROOT_W]) |->
      (out_dat_r[ROOT_W-1:0] == INDEX_SAT && !out_dat_r[ROOT_W+1]))
    else $error("pole result not saturated");

  a_clamp_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_dat_r[ROOT_W+1]) |-> (out_dat_r[ROOT_W-1:0] == INDEX_ONE))
    else $error("clamped result is not one");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!sk_vld_r && out_vld_r && !out_tready && tail_v) |=> sk_vld_r)
    else $error("stalled word lost instead of entering the skid");

endmodule

@@ sim/sellmeier_refractive_index_test.sv @@
// Self-checking testbench for the Sellmeier refractive index pipeline.
// Depends on sri_pkg and the sellmeier_refractive_index block.
// Covers coefficient writes, directed wavelengths and random wavelengths.
module sellmeier_refractive_index_test;
  import sri_pkg::*;

  typedef struct packed {
    logic [31:0] index_value;
    logic        pole_hit;
    logic        floor_clamped;
  } index_word_t;

  // One row of directed stimulus; typed_result marks rows with a known answer.
  typedef struct packed {
    logic [15:0] wave;
    logic        typed_result;
    index_word_t answer;
  } wave_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_B1;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the coefficients: [0..2] = B, [3..5] = C.
  logic [31:0] coef_copy [6];
  index_word_t expected_index_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          poles_seen = 0;
  int          clamps_seen = 0;
  bit          long_hold_req = 1'b0;

  sellmeier_refractive_index dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Squared wavelength in Q8.24 square micrometres, rounded to nearest.
  function automatic logic [63:0] wave_sq_um(input logic [15:0] w);
    logic [63:0] wl;
    wl = {48'd0, w};
    return (wl * wl * 64 + 7812) / 15625;
  endfunction

  function automatic index_word_t sellmeier_index(input logic [15:0] w);
    index_word_t r;
    longint signed n2, d;
    logic [63:0] l2, mag, num;
    r = '0;
    l2 = wave_sq_um(w);
    n2 = longint'(ONE_Q28);
    for (int k = 0; k < NTERMS; k++) begin
      d = longint'(l2) - longint'({32'd0, coef_copy[k+3]});
      if (d == 0) begin
        r.pole_hit = 1'b1;
      end else begin
        mag = (d > 0) ? d : -d;
        num = {32'd0, coef_copy[k]} * l2 * 16;
        if (d > 0) n2 = n2 + longint'(num / mag);
        else       n2 = n2 - longint'(num / mag);
      end
    end
    if (r.pole_hit) begin
      r.index_value = '1;
    end else begin
      if (n2 < longint'(ONE_Q28)) begin
        n2 = longint'(ONE_Q28);
        r.floor_clamped = 1'b1;
      end
      if (n2 >= longint'(N2_LIMIT)) r.index_value = '1;
      else r.index_value = 32'(int_sqrt(n2 << 28));
    end
    return r;
  endfunction

  // Predict on every accepted input word, check every accepted output word.
  always @(posedge clk) begin
    index_word_t got, want;
    if (rst_n && in_tvalid && in_tready) expected_index_q.push_back(sellmeier_index(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser[0], out_tuser[1]};
      results_seen++;
      poles_seen += got.pole_hit;
      clamps_seen += got.floor_clamped;
      if (expected_index_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_index_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("index mismatch: exp %h/%b/%b got %h/%b/%b", want.index_value,
                     want.pole_hit, want.floor_clamped, got.index_value,
                     got.pole_hit, got.floor_clamped);
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        2: out_tready = ($urandom_range(0, 1) != 0);
        default: out_tready = ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Write one coefficient register; indexes 6 and 7 are dropped by the block.
  task automatic write_coef(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_C3) coef_copy[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] b1, b2, b3, c1, c2, c3);
    write_coef(CFG_B1, b1);
    write_coef(CFG_B2, b2);
    write_coef(CFG_B3, b3);
    write_coef(CFG_C1, c1);
    write_coef(CFG_C2, c2);
    write_coef(CFG_C3, c3);
  endtask

  int burst_left = 0;

  // Offer one word, sometimes after an idle gap. Valid stays high across back-to-back words.
  task automatic send_wave(input logic [15:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata = w;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (expected_index_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // Typed answers of directed rows are checked here against the predictor.
  task automatic run_rows(input wave_row_t rows []);
    foreach (rows[i]) begin
      if (rows[i].typed_result && sellmeier_index(rows[i].wave) !== rows[i].answer) begin
        mismatches++;
        if (mismatches <= 10) $display("typed row %0d disagrees with prediction", i);
      end
      send_wave(rows[i].wave);
    end
  endtask

  // Random wavelength: full range, low values, near a C pole, or right on it.
  function automatic logic [15:0] pick_wave(input logic [15:0] pole_wave);
    case ($urandom_range(0, 9))
      0: return pole_wave;
      1, 2: return pole_wave + 16'($urandom_range(0, 64)) - 16'd32;
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("sellmeier_refractive_index_test: errors");
    $finish;
  end

  initial begin
    wave_row_t rows [];
    logic [15:0] pole_wave;
    for (int k = 0; k < 6; k++) coef_copy[k] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // After reset every C is zero: a wavelength whose square rounds to zero
    // is a pole, others give one.
    rows = '{
      '{16'd0,      1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{16'd1,      1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{16'hFFFF,   1'b1, '{32'h1000_0000, 1'b0, 1'b0}},
      '{16'h8000,   1'b1, '{32'h1000_0000, 1'b0, 1'b0}}};
    run_rows(rows);
    drain();

    // Glass-like coefficients; one C placed exactly on a sampled wavelength.
    pole_wave = 16'd40000;
    write_all(32'd17442140, 32'd3876900, 32'd17709640, 32'd100740,
              32'(wave_sq_um(pole_wave)), 32'd1737400000);
    write_coef(3'd6, 32'hDEAD_BEEF);
    write_coef(3'd7, 32'h1234_5678);
    rows = '{
      '{16'd0,      1'b1, '{32'h1000_0000, 1'b0, 1'b0}},
      '{pole_wave,  1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{16'hFFFF,   1'b0, '0}, '{16'd37440, 1'b0, '0}, '{16'd1,     1'b0, '0},
      '{16'd39999,  1'b0, '0}, '{16'd40001, 1'b0, '0}, '{16'h5555,  1'b0, '0},
      '{16'hAAAA,   1'b0, '0}, '{16'd20000, 1'b0, '0}};
    run_rows(rows);
    drain();

    // Extremes: huge B with C above every L clamps; huge B with C of one saturates.
    write_all('1, '1, '1, '1, '1, '1);
    rows = '{
      '{16'd0,      1'b1, '{32'h1000_0000, 1'b0, 1'b0}},
      '{16'hFFFF,   1'b1, '{32'h1000_0000, 1'b0, 1'b1}},
      '{16'd30000,  1'b1, '{32'h1000_0000, 1'b0, 1'b1}}};
    run_rows(rows);
    drain();
    write_all('1, '1, '1, 32'd1, 32'd1, 32'd1);
    rows = '{
      '{16'hFFFF,   1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{16'd0,      1'b1, '{32'h1000_0000, 1'b0, 1'b0}},
      '{16'd100,    1'b0, '0}};
    run_rows(rows);
    drain();

    // Random phases with fresh coefficients; the first one fills the pipe under a long stall.
    for (int ph = 0; ph < 8; ph++) begin
      pole_wave = 16'($urandom);
      write_all($urandom_range(0, 3) == 0 ? 32'($urandom) : $urandom_range(0, 32'h0400_0000),
                $urandom_range(0, 32'h0200_0000), 32'($urandom),
                32'(wave_sq_um(pole_wave)), $urandom_range(0, 32'h0110_0000),
                $urandom_range(0, 1) ? 32'($urandom) : 32'd0);
      write_coef(cfg_idx_t'($urandom_range(6, 7)), 32'($urandom));
      if (ph == 0) long_hold_req = 1'b1;
      repeat (235) send_wave(pick_wave(pole_wave));
      drain();
    end

    $display("covered %0d results (%0d poles, %0d clamped) over 12 coefficient sets",
             results_seen, poles_seen, clamps_seen);
    if (mismatches == 0) begin
      $display("sellmeier_refractive_index_test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sellmeier_refractive_index_test: errors");
    end
    $finish;
  end

endmodule
